@@ src/dexp_pkg.sv @@
// ----------------------------------------------------------------------------
// dexp_pkg
// Shared types, constants and tables of the downward expander.
// ----------------------------------------------------------------------------
package dexp_pkg;

    localparam int unsigned DefChannels   = 2;
    localparam int unsigned DefSampleBits = 24;

    localparam int unsigned EnvW   = 32;
    localparam int unsigned CoefW  = 24;
    localparam int unsigned ThrW   = 17;
    localparam int unsigned SlopeW = 12;
    localparam int unsigned CutW   = 15;
    localparam int unsigned GainW  = 17;
    localparam int unsigned CfgAW  = 3;
    localparam int unsigned QDepth = 2;

    localparam logic [26:0] DbPerOct = 27'd101008905;
    localparam logic [21:0] OctPerDb = 22'd2786635;
    localparam int unsigned ExpBits  = 10;

    localparam logic [CfgAW-1:0] REG_ATTACK    = 3'd0;
    localparam logic [CfgAW-1:0] REG_RELEASE   = 3'd1;
    localparam logic [CfgAW-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [CfgAW-1:0] REG_SLOPE     = 3'd3;
    localparam logic [CfgAW-1:0] REG_MAX_CUT   = 3'd4;

    localparam logic [CoefW-1:0]       RstAttack    = 24'd16707425;
    localparam logic [CoefW-1:0]       RstRelease   = 24'd16774886;
    localparam logic signed [ThrW-1:0] RstThreshold = -17'sd10752;
    localparam logic [SlopeW-1:0]      RstSlope     = 12'd256;
    localparam logic [CutW-1:0]        RstMaxCut    = 15'd2560;

    typedef struct packed {
        logic [CoefW-1:0]       attack;
        logic [CoefW-1:0]       rel_coeff;
        logic signed [ThrW-1:0] threshold;
        logic [SlopeW-1:0]      slope;
        logic [CutW-1:0]        max_cut;
    } t_cfg;

    // 2^(-2^-(k+1)) in q30
    function automatic logic [29:0] pow_factor(input logic [3:0] k);
        logic [29:0] r;
        case (k)
            4'd0:    r = 30'd759250125;
            4'd1:    r = 30'd902905659;
            4'd2:    r = 30'd984625591;
            4'd3:    r = 30'd1028238693;
            4'd4:    r = 30'd1050733760;
            4'd5:    r = 30'd1062175498;
            4'd6:    r = 30'd1067942995;
            4'd7:    r = 30'd1070838492;
            4'd8:    r = 30'd1072289169;
            4'd9:    r = 30'd1073015245;
            default: r = 30'd1073741823;
        endcase
        return r;
    endfunction

endpackage

@@ src/downward_expander.sv @@
// ----------------------------------------------------------------------------
// downward_expander
// Wide-band downward expander for multichannel Q1.23 audio frames.
// ----------------------------------------------------------------------------
// channel   dir  request                      handshake
// s_axis    in   one frame, ch0 in low bits   s_axis_tvalid / s_axis_tready
// m_axis    out  gained frame, then gain      m_axis_tvalid / m_axis_tready
// cfg       in   register index and value     i_cfg_valid / o_cfg_ready
//
// in the back end a frame runs three envelope steps, sixteen log squaring
// steps, ten exponent factor steps and one gain multiply per channel on a
// shared multiplier.
// a two-entry queue sits between the peak detector and the back end.
// the result register frees the back end while a result waits on m_axis.
// synchronous active-low reset clears the envelope and loads default registers.
// ----------------------------------------------------------------------------
module downward_expander #(
    parameter int unsigned CHANNELS    = dexp_pkg::DefChannels,
    parameter int unsigned SAMPLE_BITS = dexp_pkg::DefSampleBits
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // sample_ch0 .. sample_chN
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // out_ch0 .. out_chN, gain_linear
    output logic [((CHANNELS*SAMPLE_BITS+17+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [dexp_pkg::CfgAW-1:0]                 i_cfg_addr,
    input  logic [dexp_pkg::CoefW-1:0]                 i_cfg_data
);
    import dexp_pkg::*;

    localparam int unsigned FW   = CHANNELS * SAMPLE_BITS;
    localparam int unsigned RW   = FW + GainW;
    localparam int unsigned OutW = ((RW + 7) / 8) * 8;

    t_cfg          r_cfg;
    logic          w_q_valid, w_q_ready;
    logic [FW-1:0] w_q_samples;
    logic [31:0]   w_q_det;
    logic [RW-1:0] w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack    <= RstAttack;
            r_cfg.rel_coeff <= RstRelease;
            r_cfg.threshold <= RstThreshold;
            r_cfg.slope     <= RstSlope;
            r_cfg.max_cut   <= RstMaxCut;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_ATTACK:    r_cfg.attack    <= i_cfg_data;
                REG_RELEASE:   r_cfg.rel_coeff <= i_cfg_data;
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[ThrW-1:0];
                REG_SLOPE:     r_cfg.slope     <= i_cfg_data[SlopeW-1:0];
                REG_MAX_CUT:   r_cfg.max_cut   <= i_cfg_data[CutW-1:0];
                default: ;
            endcase
        end
    end

    dexp_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_samples   (s_axis_tdata[FW-1:0]),
        .o_q_valid   (w_q_valid),
        .i_q_ready   (w_q_ready),
        .o_q_samples (w_q_samples),
        .o_q_det     (w_q_det)
    );

    dexp_back #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_samples (w_q_samples),
        .i_q_det     (w_q_det),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = OutW'(w_result);

endmodule

@@ src/dexp_front.sv @@
// ----------------------------------------------------------------------------
// dexp_front
// Accepts frames, finds the peak magnitude and queues frame plus detector.
// ----------------------------------------------------------------------------
module dexp_front #(
    parameter int unsigned CHANNELS    = 2,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [CHANNELS*SAMPLE_BITS-1:0] i_samples,
    output logic                            o_q_valid,
    input  logic                            i_q_ready,
    output logic [CHANNELS*SAMPLE_BITS-1:0] o_q_samples,
    output logic [31:0]                     o_q_det
);
    import dexp_pkg::*;

    localparam int unsigned FW  = CHANNELS * SAMPLE_BITS;
    localparam int unsigned PW  = $clog2(QDepth);
    localparam int unsigned CW  = $clog2(QDepth + 1);

    logic [FW-1:0]          r_data [QDepth];
    logic [31:0]            r_det  [QDepth];
    logic [PW-1:0]          r_wp, r_rp;
    logic [CW-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0] w_mag, w_peak;
    logic [31:0]            w_det;
    logic                   w_push, w_pop;

    // peak magnitude across channels
    always_comb begin
        w_peak = '0;
        w_mag  = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_mag = i_samples[c*SAMPLE_BITS +: SAMPLE_BITS];
            if (w_mag[SAMPLE_BITS-1]) begin
                w_mag = ~w_mag + 1'b1;
            end
            if (w_mag > w_peak) begin
                w_peak = w_mag;
            end
        end
        w_det = 32'(w_peak) << (32 - SAMPLE_BITS);
    end

    assign o_tready    = (r_cnt != CW'(QDepth));
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_samples = r_data[r_rp];
    assign o_q_det     = r_det[r_rp];
    assign w_push      = i_tvalid & o_tready;
    assign w_pop       = o_q_valid & i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= PW'((32'(r_wp) + 1) % QDepth);
            end
            if (w_pop) begin
                r_rp <= PW'((32'(r_rp) + 1) % QDepth);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wp] <= i_samples;
            r_det[r_wp]  <= w_det;
        end
    end

endmodule

@@ src/dexp_back.sv @@
// ----------------------------------------------------------------------------
// dexp_back
// Envelope, log level, gain computer and gain apply, one frame at a time.
// ----------------------------------------------------------------------------
module dexp_back #(
    parameter int unsigned CHANNELS    = 2,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  dexp_pkg::t_cfg                                i_cfg,
    input  logic                                          i_q_valid,
    output logic                                          o_q_ready,
    input  logic [CHANNELS*SAMPLE_BITS-1:0]               i_q_samples,
    input  logic [31:0]                                   i_q_det,
    output logic                                          o_tvalid,
    input  logic                                          i_tready,
    output logic [CHANNELS*SAMPLE_BITS+dexp_pkg::GainW-1:0] o_result
);
    import dexp_pkg::*;

    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned FW  = CHANNELS * SB;
    localparam int unsigned RW  = FW + GainW;
    localparam int unsigned YW  = SB + 19;
    localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'h0001,
        S_ENV_A = 13'h0002,
        S_ENV_B = 13'h0004,
        S_ENV_C = 13'h0008,
        S_NORM  = 13'h0010,
        S_LOG   = 13'h0020,
        S_ATT   = 13'h0040,
        S_CUT   = 13'h0080,
        S_EXPO  = 13'h0100,
        S_POW   = 13'h0200,
        S_GAIN  = 13'h0400,
        S_APPLY = 13'h0800,
        S_DONE  = 13'h1000
    } t_state;

    t_state              r_state;
    logic [EnvW-1:0]     r_env;
    logic [31:0]         r_det;
    logic [FW-1:0]       r_samp;
    logic [CoefW-1:0]    r_coef;
    logic [55:0]         r_p1;
    logic [56:0]         r_p2;
    logic [31:0]         r_m;
    logic [4:0]          r_p;
    logic [15:0]         r_frac;
    logic [3:0]          r_cnt;
    logic [15:0]         r_att;
    logic [CutW-1:0]     r_cut;
    logic [4:0]          r_n;
    logic [15:0]         r_f;
    logic [30:0]         r_gm;
    logic [GainW-1:0]    r_gain;
    logic [ChW-1:0]      r_ch;
    logic [FW-1:0]       r_out;
    logic                r_vld;
    logic [RW-1:0]       r_res;

    logic [CoefW-1:0]    w_coef;
    logic [57:0]         w_esum;
    logic [32:0]         w_v1;
    logic [31:0]         w_v;
    logic [4:0]          w_p;
    logic [31:0]         w_mn;
    logic [61:0]         w_sq;
    logic [31:0]         w_t;
    logic [20:0]         w_l;
    logic [47:0]         w_aprod;
    logic [48:0]         w_asum;
    logic signed [18:0]  w_over;
    logic [17:0]         w_neg;
    logic [29:0]         w_cprod;
    logic [29:0]         w_c;
    logic [36:0]         w_eprod;
    logic [37:0]         w_e;
    logic [60:0]         w_gprod;
    logic [5:0]          w_s;
    logic [63:0]         w_gsum;
    logic [63:0]         w_g;
    logic signed [SB-1:0]  w_x;
    logic signed [SB+17:0] w_prod;
    logic signed [SB+18:0] w_y;
    logic [SB-1:0]         w_sat;
    logic                  w_load;

    assign o_q_ready = (r_state == S_IDLE);
    assign o_tvalid  = r_vld;
    assign o_result  = r_res;
    assign w_load    = (r_state == S_DONE) && (!r_vld || i_tready);

    always_comb begin
        w_coef  = (r_det > r_env) ? i_cfg.attack : i_cfg.rel_coeff;
        w_esum  = 58'(r_p1) + 58'(r_p2) + 58'(1 << 23);
        // level with noise floor, clamped to full scale
        w_v1    = 33'(r_env) + 33'd2;
        w_v     = w_v1[32:31] != 2'b00 ? 32'h8000_0000 : w_v1[31:0];
        w_p     = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_v[i]) begin
                w_p = 5'(i);
            end
        end
        w_mn    = (w_p == 5'd31) ? (w_v >> 1) : (w_v << (5'd30 - w_p));
        w_sq    = 62'(r_m[30:0]) * 62'(r_m[30:0]);
        w_t     = w_sq[61:30];
        w_l     = {r_p, r_frac};
        w_aprod = 48'(21'(31 << 16) - w_l) * 48'(DbPerOct);
        w_asum  = 49'(w_aprod) + 49'd2147483648;
        w_over  = -$signed({3'b000, r_att}) - 19'(i_cfg.threshold);
        w_neg   = 18'(-w_over);
        w_cprod = 30'(i_cfg.slope) * 30'(w_neg);
        w_c     = (w_cprod + 30'd128) >> 8;
        w_eprod = 37'(r_cut) * 37'(OctPerDb);
        w_e     = (38'(w_eprod) + 38'd32768) >> 16;
        w_gprod = 61'(r_gm) * 61'(pow_factor(r_cnt)) + 61'(1 << 29);
        w_s     = 6'd14 + 6'(r_n);
        w_gsum  = 64'(r_gm) + (64'd1 << (w_s - 6'd1));
        w_g     = w_gsum >> w_s;
        w_x     = r_samp[r_ch*SB +: SB];
        w_prod  = w_x * $signed({1'b0, r_gain});
        w_y     = (YW'(w_prod) + YW'(32768)) >>> 16;
        if (w_y[SB+18:SB-1] == '0 || w_y[SB+18:SB-1] == '1) begin
            w_sat = w_y[SB-1:0];
        end else if (w_y[SB+18]) begin
            w_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SB-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_env   <= '0;
            r_vld   <= 1'b0;
            r_cnt   <= '0;
            r_ch    <= '0;
        end else begin
            if (w_load) begin
                r_vld <= 1'b1;
            end else if (r_vld && i_tready) begin
                r_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_ENV_A;
                    end
                end
                S_ENV_A: r_state <= S_ENV_B;
                S_ENV_B: r_state <= S_ENV_C;
                S_ENV_C: begin
                    r_env   <= w_esum[55:24];
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_cnt   <= 4'd15;
                    r_state <= S_LOG;
                end
                S_LOG: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_ATT;
                    end
                end
                S_ATT:  r_state <= S_CUT;
                S_CUT:  r_state <= S_EXPO;
                S_EXPO: begin
                    r_cnt   <= '0;
                    r_state <= S_POW;
                end
                S_POW: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'(ExpBits - 1)) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_ch    <= '0;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_ch <= r_ch + 1'b1;
                    if (r_ch == ChW'(CHANNELS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_det  <= i_q_det;
            r_samp <= i_q_samples;
        end
        if (r_state == S_ENV_A) begin
            r_coef <= w_coef;
            r_p1   <= 56'(w_coef) * 56'(r_env);
        end
        if (r_state == S_ENV_B) begin
            r_p2 <= 57'(25'(1 << 24) - 25'(r_coef)) * 57'(r_det);
        end
        if (r_state == S_NORM) begin
            r_m    <= w_mn;
            r_p    <= w_p;
            r_frac <= '0;
        end
        if (r_state == S_LOG) begin
            if (w_t[31]) begin
                r_frac[r_cnt] <= 1'b1;
                r_m           <= w_t >> 1;
            end else begin
                r_m <= w_t;
            end
        end
        if (r_state == S_ATT) begin
            r_att <= w_asum[47:32];
        end
        if (r_state == S_CUT) begin
            if (!w_over[18]) begin
                r_cut <= '0;
            end else if (w_c > 30'(i_cfg.max_cut)) begin
                r_cut <= i_cfg.max_cut;
            end else begin
                r_cut <= w_c[CutW-1:0];
            end
        end
        if (r_state == S_EXPO) begin
            r_n  <= w_e[20:16];
            r_f  <= w_e[15:0];
            r_gm <= 31'(1 << 30);
        end
        if (r_state == S_POW && r_f[4'd15 - r_cnt]) begin
            r_gm <= w_gprod[60:30];
        end
        if (r_state == S_GAIN) begin
            r_gain <= w_g[GainW-1:0];
        end
        if (r_state == S_APPLY) begin
            r_out[r_ch*SB +: SB] <= w_sat;
        end
        if (w_load) begin
            r_res <= {r_gain, r_out};
        end
    end

endmodule
